[sv/pla_pkg.sv]
// Shared types and constants for the previous-arrangement stepper.
// No dependencies; every other file but pla_ram takes names from here by scope.
`timescale 1ns / 1ps
package pla_pkg;

	localparam int POS_W  = 5;
	localparam int IDX_W  = 6;
	localparam int REQ_W  = 2;
	localparam int MODE_W = 3;
	localparam int TOP_W  = 8;
	localparam int LAST_W = 5;
	localparam int MLEN_W = 7;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [REQ_W-1:0] REQ_LOAD_ARR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_MS  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STEP     = 2'd2;

	localparam logic [MODE_W-1:0] MODE_COMB     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_COMB_REP = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MULTI    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FULL     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PART     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REP      = 3'd5;

	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_TOP      = 2'd1;
	localparam logic [1:0] REG_LAST     = 2'd2;
	localparam logic [1:0] REG_MULTILEN = 2'd3;

	typedef struct packed {
		logic arr_we;
		logic ms_we;
		logic out_load;
		logic out_last;
		logic out_flag;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

[sv/pla_if.sv]
// Valid/ready channel interfaces for request and result words.
// Depends on pla_pkg for field widths.
`timescale 1ns / 1ps
interface pla_in_if #(parameter int VALUE_BITS = 8) ();
	logic                        valid;
	logic                        ready;
	logic [pla_pkg::REQ_W-1:0]   req_type;
	logic [pla_pkg::IDX_W-1:0]   index;
	logic [VALUE_BITS-1:0]       value;
	modport source (output valid, req_type, index, value, input ready);
	modport sink (input valid, req_type, index, value, output ready);
endinterface

interface pla_out_if #(parameter int VALUE_BITS = 8) ();
	logic                        valid;
	logic                        ready;
	logic [pla_pkg::POS_W-1:0]   position;
	logic [VALUE_BITS-1:0]       element;
	logic                        last;
	logic                        no_previous;
	modport source (output valid, position, element, last, no_previous, input ready);
	modport sink (input valid, position, element, last, no_previous, output ready);
endinterface

[sv/pla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/pla_datapath.sv]
// Datapath: arrangement and multiset RAMs plus the result output register.
// Depends on pla_pkg, pla_if and pla_ram.
`timescale 1ns / 1ps
module pla_datapath #(
	parameter int MAX_LEN    = 32,
	parameter int MAX_MULTI  = 64,
	parameter int VALUE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pla_pkg::cmd_t                 cmd,
	output pla_pkg::sts_t                 sts,
	input  logic [$clog2(MAX_LEN)-1:0]    arr_waddr,
	input  logic [VALUE_BITS-1:0]         arr_wdata,
	input  logic [$clog2(MAX_LEN)-1:0]    arr_raddr,
	output logic [VALUE_BITS-1:0]         arr_rdata,
	input  logic [$clog2(MAX_MULTI)-1:0]  ms_waddr,
	input  logic [VALUE_BITS-1:0]         ms_wdata,
	input  logic [$clog2(MAX_MULTI)-1:0]  ms_raddr,
	output logic [VALUE_BITS-1:0]         ms_rdata,
	input  logic [pla_pkg::POS_W-1:0]     out_pos,
	input  logic [VALUE_BITS-1:0]         out_elem,
	pla_out_if.source                     out_ch
);
	logic                        out_valid_q;
	logic [pla_pkg::POS_W-1:0]   pos_q;
	logic [VALUE_BITS-1:0]       elem_q;
	logic                        last_q;
	logic                        flag_q;

	pla_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_arr (
		.clk(clk), .we(cmd.arr_we), .waddr(arr_waddr), .wdata(arr_wdata),
		.raddr(arr_raddr), .rdata(arr_rdata)
	);

	pla_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_MULTI)) u_ms (
		.clk(clk), .we(cmd.ms_we), .waddr(ms_waddr), .wdata(ms_wdata),
		.raddr(ms_raddr), .rdata(ms_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pos_q  <= out_pos;
			elem_q <= out_elem;
			last_q <= cmd.out_last;
			flag_q <= cmd.out_flag;
		end
	end

	assign sts.out_free       = !out_valid_q || out_ch.ready;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.position    = pos_q;
	assign out_ch.element     = elem_q;
	assign out_ch.last        = last_q;
	assign out_ch.no_previous = flag_q;
endmodule

[sv/pla_ctrl.sv]
// Controller: sequencer that walks each arrangement kind one RAM access at a time.
// Depends on pla_pkg and pla_if; drives the datapath by commands, addresses and write data.
`timescale 1ns / 1ps
module pla_ctrl #(
	parameter int MAX_LEN    = 32,
	parameter int MAX_MULTI  = 64,
	parameter int VALUE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pla_in_if.sink                        in_ch,
	input  logic [pla_pkg::MODE_W-1:0]    mode,
	input  logic [pla_pkg::TOP_W-1:0]     top_value,
	input  logic [pla_pkg::LAST_W-1:0]    last_pos,
	input  logic [pla_pkg::MLEN_W-1:0]    multiset_len,
	output pla_pkg::cmd_t                 cmd,
	input  pla_pkg::sts_t                 sts,
	output logic [$clog2(MAX_LEN)-1:0]    arr_waddr,
	output logic [VALUE_BITS-1:0]         arr_wdata,
	output logic [$clog2(MAX_LEN)-1:0]    arr_raddr,
	input  logic [VALUE_BITS-1:0]         arr_rdata,
	output logic [$clog2(MAX_MULTI)-1:0]  ms_waddr,
	output logic [VALUE_BITS-1:0]         ms_wdata,
	output logic [$clog2(MAX_MULTI)-1:0]  ms_raddr,
	input  logic [VALUE_BITS-1:0]         ms_rdata,
	output logic [pla_pkg::POS_W-1:0]     out_pos,
	output logic [VALUE_BITS-1:0]         out_elem
);
	localparam int VB = VALUE_BITS;
	localparam int PW = $clog2(MAX_LEN);
	localparam int MW = $clog2(MAX_MULTI);
	localparam int SW = PW + 2;
	localparam int KW = $clog2(MAX_MULTI + 1);
	localparam int BW = KW + SW + 1;
	localparam int CW = ((VB > SW) ? VB : SW) + 2;
	localparam int AW = $clog2(MAX_MULTI + MAX_LEN + 1) + 1;

	typedef enum logic [5:0] {
		S_IDLE,
		S_C_AM, S_C_AMD, S_C_RI, S_C_RID, S_C_CHK, S_C_FILL,
		S_R_R, S_R_D,
		S_M_RI, S_M_RID, S_M_RP, S_M_RPD, S_M_TEST, S_M_CMS, S_M_CMSD,
		S_M_CA, S_M_CAD, S_M_NEXT, S_M_PK, S_M_PKD, S_M_FR, S_M_FD,
		S_F_H, S_F_HD, S_F_P, S_F_PD, S_F_Q, S_F_QD, S_F_RV,
		S_P_A, S_P_AD, S_P_S, S_P_SD, S_P_Q2, S_P_Q, S_P_QD, S_P_R2,
		S_RV, S_SW_R1, S_SW_R2, S_SW_W1, S_SW_W2,
		S_EM0, S_EM_R, S_EM_D
	} state_t;

	state_t state_q, swap_ret_q, rev_ret_q;

	logic signed [SW-1:0] i_q, j_q, p1_q, p2_q, lo_q, hi_q, sx_q, sy_q;
	logic [KW-1:0]        k_q;
	logic [VB-1:0]        va_q, vb_q, t1_q;
	logic signed [AW-1:0] cnt_q;
	logic                 flag_q;

	logic signed [SW-1:0] m_w, n1p_w, ma_w;
	logic [KW-1:0]        len_w;
	logic [VB+7:0]        tv_ext;
	logic [VB-1:0]        n1v, fill0, va_dec;
	logic signed [BW-1:0] b_w, len_s;
	logic                 b_ok;
	logic signed [CW-1:0] d_val, d_pos;
	logic                 c_match;
	logic                 accept;

	assign m_w   = (int'(last_pos) > MAX_LEN - 1) ? SW'(MAX_LEN - 1) : SW'(last_pos);
	assign n1p_w = (int'(top_value) > MAX_LEN - 1) ? SW'(MAX_LEN - 1) : SW'(top_value);
	assign ma_w  = (m_w > n1p_w) ? n1p_w : m_w;
	assign len_w = (int'(multiset_len) > MAX_MULTI) ? KW'(MAX_MULTI) : KW'(multiset_len);
	assign tv_ext = (VB + 8)'(top_value);
	assign n1v    = tv_ext[VB-1:0];
	assign fill0  = n1v - VB'(m_w) + VB'(j_q);
	assign va_dec = va_q - VB'(1);
	assign len_s  = $signed(BW'(len_w));
	assign b_w    = len_s + BW'(j_q) - BW'(m_w) - BW'(1);
	assign b_ok   = (b_w >= 0) && (b_w < len_s);
	assign d_val  = $signed(CW'(vb_q)) - $signed(CW'(arr_rdata));
	assign d_pos  = CW'(m_w) - CW'(i_q);
	assign c_match = (mode == pla_pkg::MODE_COMB) ? (d_val == d_pos) : (arr_rdata == vb_q);
	assign accept = in_ch.valid && (state_q == S_IDLE);
	assign in_ch.ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.out_last = (j_q == m_w);
		cmd.out_flag = flag_q;
		arr_waddr = PW'(i_q);
		arr_wdata = va_q;
		arr_raddr = PW'(i_q);
		ms_waddr  = MW'(in_ch.index);
		ms_wdata  = in_ch.value;
		ms_raddr  = MW'(k_q);
		out_pos   = pla_pkg::POS_W'(j_q);
		out_elem  = arr_rdata;
		unique case (state_q)
			S_IDLE: begin
				if (in_ch.valid && in_ch.req_type == pla_pkg::REQ_LOAD_ARR &&
						int'(in_ch.index) < MAX_LEN) begin
					cmd.arr_we = 1'b1;
					arr_waddr  = PW'(in_ch.index);
					arr_wdata  = in_ch.value;
				end
				if (in_ch.valid && in_ch.req_type == pla_pkg::REQ_LOAD_MS &&
						int'(in_ch.index) < MAX_MULTI) begin
					cmd.ms_we = 1'b1;
				end
			end
			S_C_AM: arr_raddr = PW'(m_w);
			S_C_CHK: begin
				if (va_q != '0) begin
					cmd.arr_we = 1'b1;
					arr_wdata  = va_dec;
				end
			end
			S_C_FILL: begin
				if (j_q <= m_w) begin
					cmd.arr_we = 1'b1;
					arr_waddr  = PW'(j_q);
					arr_wdata  = (mode == pla_pkg::MODE_COMB) ? fill0 : n1v;
				end
			end
			S_R_D: begin
				cmd.arr_we = 1'b1;
				arr_wdata  = (arr_rdata != '0) ? arr_rdata - VB'(1) : n1v;
			end
			S_M_RP: arr_raddr = PW'(i_q - SW'(1));
			S_M_CA: arr_raddr = PW'(j_q);
			S_M_PKD: begin
				if (arr_rdata != '0) begin
					cmd.arr_we = 1'b1;
					arr_wdata  = arr_rdata - VB'(1);
				end
			end
			S_M_FR: begin
				ms_raddr = MW'(b_w);
				if (j_q <= m_w && !b_ok) begin
					cmd.arr_we = 1'b1;
					arr_waddr  = PW'(j_q);
					arr_wdata  = '0;
				end
			end
			S_M_FD: begin
				cmd.arr_we = 1'b1;
				arr_waddr  = PW'(j_q);
				arr_wdata  = ms_rdata;
			end
			S_F_H: arr_raddr = PW'(p1_q + SW'(1));
			S_F_P, S_P_S: arr_raddr = PW'(p1_q);
			S_F_Q, S_P_Q: arr_raddr = PW'(p2_q);
			S_P_A: arr_raddr = PW'(ma_w);
			S_SW_R1: arr_raddr = PW'(sx_q);
			S_SW_R2: arr_raddr = PW'(sy_q);
			S_SW_W1: begin
				cmd.arr_we = 1'b1;
				arr_waddr  = PW'(sx_q);
				arr_wdata  = arr_rdata;
			end
			S_SW_W2: begin
				cmd.arr_we = 1'b1;
				arr_waddr  = PW'(sy_q);
				arr_wdata  = t1_q;
			end
			S_EM_R: arr_raddr = PW'(j_q);
			S_EM_D: begin
				arr_raddr    = PW'(j_q);
				cmd.out_load = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			swap_ret_q <= S_IDLE;
			rev_ret_q  <= S_IDLE;
			flag_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_ch.req_type == pla_pkg::REQ_STEP) begin
						flag_q <= 1'b0;
						priority case (mode)
							pla_pkg::MODE_COMB, pla_pkg::MODE_COMB_REP: state_q <= S_C_AM;
							pla_pkg::MODE_MULTI: begin
								i_q     <= m_w;
								state_q <= (m_w == 0) ? S_M_PK : S_M_RI;
							end
							pla_pkg::MODE_FULL: begin
								if (n1p_w == 0) begin
									flag_q  <= 1'b1;
									state_q <= S_EM0;
								end else begin
									p1_q    <= n1p_w - SW'(1);
									state_q <= S_F_H;
								end
							end
							pla_pkg::MODE_PART: state_q <= S_P_A;
							pla_pkg::MODE_REP: begin
								i_q     <= m_w;
								state_q <= S_R_R;
							end
							default: state_q <= S_EM0;
						endcase
					end
				end
				S_C_AM: state_q <= S_C_AMD;
				S_C_AMD: begin
					vb_q <= arr_rdata;
					if (m_w == 0) begin
						i_q     <= m_w;
						va_q    <= arr_rdata;
						state_q <= S_C_CHK;
					end else begin
						i_q     <= '0;
						state_q <= S_C_RI;
					end
				end
				S_C_RI: state_q <= S_C_RID;
				S_C_RID: begin
					if (c_match) begin
						va_q    <= arr_rdata;
						state_q <= S_C_CHK;
					end else if (i_q + SW'(1) == m_w) begin
						i_q     <= m_w;
						va_q    <= vb_q;
						state_q <= S_C_CHK;
					end else begin
						i_q     <= i_q + SW'(1);
						state_q <= S_C_RI;
					end
				end
				S_C_CHK: begin
					if (va_q == '0) begin
						flag_q  <= 1'b1;
						state_q <= S_EM0;
					end else begin
						j_q     <= i_q + SW'(1);
						state_q <= S_C_FILL;
					end
				end
				S_C_FILL: begin
					if (j_q > m_w) state_q <= S_EM0;
					else j_q <= j_q + SW'(1);
				end
				S_R_R: state_q <= S_R_D;
				S_R_D: begin
					if (arr_rdata != '0 || i_q == 0) begin
						state_q <= S_EM0;
					end else begin
						i_q     <= i_q - SW'(1);
						state_q <= S_R_R;
					end
				end
				S_M_RI: state_q <= S_M_RID;
				S_M_RID: begin
					va_q    <= arr_rdata;
					state_q <= (i_q > 0) ? S_M_RP : S_M_TEST;
				end
				S_M_RP: state_q <= S_M_RPD;
				S_M_RPD: begin
					if (arr_rdata == va_q) begin
						i_q     <= i_q - SW'(1);
						state_q <= (i_q > 1) ? S_M_RP : S_M_TEST;
					end else begin
						state_q <= S_M_TEST;
					end
				end
				S_M_TEST: begin
					if (va_q != '0) begin
						cnt_q   <= '0;
						k_q     <= '0;
						state_q <= S_M_CMS;
					end else begin
						state_q <= S_M_NEXT;
					end
				end
				S_M_CMS: begin
					if (k_q < len_w) begin
						state_q <= S_M_CMSD;
					end else begin
						j_q     <= '0;
						state_q <= S_M_CA;
					end
				end
				S_M_CMSD: begin
					if (ms_rdata == va_dec) cnt_q <= cnt_q + AW'(1);
					k_q     <= k_q + KW'(1);
					state_q <= S_M_CMS;
				end
				S_M_CA: begin
					if (j_q <= m_w) state_q <= S_M_CAD;
					else if (cnt_q > 0) state_q <= S_M_PK;
					else state_q <= S_M_NEXT;
				end
				S_M_CAD: begin
					if (arr_rdata == va_dec) cnt_q <= cnt_q - AW'(1);
					j_q     <= j_q + SW'(1);
					state_q <= S_M_CA;
				end
				S_M_NEXT: begin
					if (i_q > 1) begin
						i_q     <= i_q - SW'(1);
						state_q <= S_M_RI;
					end else begin
						i_q     <= '0;
						state_q <= S_M_PK;
					end
				end
				S_M_PK: state_q <= S_M_PKD;
				S_M_PKD: begin
					if (arr_rdata == '0) begin
						flag_q  <= 1'b1;
						state_q <= S_EM0;
					end else begin
						j_q     <= i_q + SW'(1);
						state_q <= S_M_FR;
					end
				end
				S_M_FR: begin
					if (j_q > m_w) state_q <= S_EM0;
					else if (b_ok) state_q <= S_M_FD;
					else j_q <= j_q + SW'(1);
				end
				S_M_FD: begin
					j_q     <= j_q + SW'(1);
					state_q <= S_M_FR;
				end
				S_F_H: state_q <= S_F_HD;
				S_F_HD: begin
					vb_q    <= arr_rdata;
					state_q <= S_F_P;
				end
				S_F_P: state_q <= S_F_PD;
				S_F_PD: begin
					if (vb_q >= arr_rdata) begin
						vb_q <= arr_rdata;
						if (p1_q == 0) begin
							flag_q  <= 1'b1;
							state_q <= S_EM0;
						end else begin
							p1_q    <= p1_q - SW'(1);
							state_q <= S_F_P;
						end
					end else begin
						va_q <= arr_rdata;
						if (mode == pla_pkg::MODE_FULL) begin
							p2_q    <= n1p_w;
							state_q <= S_F_Q;
						end else begin
							lo_q      <= p1_q + SW'(1);
							hi_q      <= n1p_w;
							rev_ret_q <= S_P_Q2;
							state_q   <= S_RV;
						end
					end
				end
				S_F_Q: begin
					if (p2_q > p1_q + SW'(1)) begin
						state_q <= S_F_QD;
					end else begin
						sx_q       <= p1_q;
						sy_q       <= p2_q;
						swap_ret_q <= S_F_RV;
						state_q    <= S_SW_R1;
					end
				end
				S_F_QD: begin
					if (arr_rdata >= va_q) begin
						p2_q    <= p2_q - SW'(1);
						state_q <= S_F_Q;
					end else begin
						sx_q       <= p1_q;
						sy_q       <= p2_q;
						swap_ret_q <= S_F_RV;
						state_q    <= S_SW_R1;
					end
				end
				S_F_RV: begin
					lo_q      <= p1_q + SW'(1);
					hi_q      <= n1p_w;
					rev_ret_q <= S_EM0;
					state_q   <= S_RV;
				end
				S_P_A: state_q <= S_P_AD;
				S_P_AD: begin
					vb_q    <= arr_rdata;
					p1_q    <= n1p_w;
					state_q <= S_P_S;
				end
				S_P_S: begin
					if (p1_q > ma_w) begin
						state_q <= S_P_SD;
					end else if (n1p_w == 0) begin
						flag_q  <= 1'b1;
						state_q <= S_EM0;
					end else begin
						p1_q    <= (ma_w < n1p_w) ? ma_w : n1p_w - SW'(1);
						state_q <= S_F_H;
					end
				end
				S_P_SD: begin
					if (arr_rdata >= vb_q) begin
						p1_q    <= p1_q - SW'(1);
						state_q <= S_P_S;
					end else begin
						sx_q       <= p1_q;
						sy_q       <= ma_w;
						swap_ret_q <= S_EM0;
						state_q    <= S_SW_R1;
					end
				end
				S_P_Q2: begin
					p2_q    <= p1_q + SW'(1);
					state_q <= S_P_Q;
				end
				S_P_Q: begin
					if (p2_q < n1p_w) begin
						state_q <= S_P_QD;
					end else begin
						sx_q       <= p1_q;
						sy_q       <= p2_q;
						swap_ret_q <= S_P_R2;
						state_q    <= S_SW_R1;
					end
				end
				S_P_QD: begin
					if (arr_rdata >= va_q) begin
						p2_q    <= p2_q + SW'(1);
						state_q <= S_P_Q;
					end else begin
						sx_q       <= p1_q;
						sy_q       <= p2_q;
						swap_ret_q <= S_P_R2;
						state_q    <= S_SW_R1;
					end
				end
				S_P_R2: begin
					lo_q      <= ma_w + SW'(1);
					hi_q      <= n1p_w;
					rev_ret_q <= S_EM0;
					state_q   <= S_RV;
				end
				S_RV: begin
					if (lo_q < hi_q) begin
						sx_q       <= lo_q;
						sy_q       <= hi_q;
						lo_q       <= lo_q + SW'(1);
						hi_q       <= hi_q - SW'(1);
						swap_ret_q <= S_RV;
						state_q    <= S_SW_R1;
					end else begin
						state_q <= rev_ret_q;
					end
				end
				S_SW_R1: state_q <= S_SW_R2;
				S_SW_R2: begin
					t1_q    <= arr_rdata;
					state_q <= S_SW_W1;
				end
				S_SW_W1: state_q <= S_SW_W2;
				S_SW_W2: state_q <= swap_ret_q;
				S_EM0: begin
					j_q     <= '0;
					state_q <= S_EM_R;
				end
				S_EM_R: state_q <= S_EM_D;
				S_EM_D: begin
					if (sts.out_free) begin
						if (j_q == m_w) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + SW'(1);
							state_q <= S_EM_R;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result word loaded while output register is held");

	a_last_ends_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EM_D && sts.out_free && j_q == m_w) |=> state_q == S_IDLE)
		else $error("step did not finish after its last word");

	a_rep_never_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flag_q) |-> (mode != pla_pkg::MODE_REP))
		else $error("no_previous raised in wrapping mode");

	a_no_write_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EM_R || state_q == S_EM_D) |-> !cmd.arr_we)
		else $error("arrangement written while results are streamed");
endmodule

[sv/prev_lexicographic_arrangement_unit.sv]
// Top level: APB config registers, controller and datapath of the arrangement stepper.
// Depends on pla_pkg, pla_if, pla_ctrl and pla_datapath.
// Timing: a load word is written while idle; a step runs a setup walk over the RAM, then emits
//   last_pos+1 words as the output has room. Setup is O(m) RAM reads in most modes and
//   about m*(multiset_len+m) reads in multiset mode, set by the single arrangement read port.
// Throughput: one word at a time; the next request is taken after the last result is loaded.
// Reset: registers return to mode 0, top_value 0, last_pos 0, multiset_len 1; stores stay
//   undefined until written, with no clearing pass.
`timescale 1ns / 1ps
module prev_lexicographic_arrangement_unit #(
	parameter int MAX_LEN    = 32,
	parameter int MAX_MULTI  = 64,
	parameter int VALUE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pla_pkg::ADDR_W-1:0]    paddr,
	input  logic [pla_pkg::DATA_W-1:0]    pwdata,
	output logic [pla_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	pla_in_if.sink                        in_ch,
	pla_out_if.source                     out_ch
);
	logic [pla_pkg::MODE_W-1:0]  mode_q;
	logic [pla_pkg::TOP_W-1:0]   top_q;
	logic [pla_pkg::LAST_W-1:0]  last_q;
	logic [pla_pkg::MLEN_W-1:0]  mlen_q;
	logic                        wr_en;

	pla_pkg::cmd_t                 cmd;
	pla_pkg::sts_t                 sts;
	logic [$clog2(MAX_LEN)-1:0]    arr_waddr, arr_raddr;
	logic [VALUE_BITS-1:0]         arr_wdata, arr_rdata, ms_wdata, ms_rdata, out_elem;
	logic [$clog2(MAX_MULTI)-1:0]  ms_waddr, ms_raddr;
	logic [pla_pkg::POS_W-1:0]     out_pos;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			top_q  <= '0;
			last_q <= '0;
			mlen_q <= pla_pkg::MLEN_W'(1);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				pla_pkg::REG_MODE:     mode_q <= pwdata[pla_pkg::MODE_W-1:0];
				pla_pkg::REG_TOP:      top_q  <= pwdata[pla_pkg::TOP_W-1:0];
				pla_pkg::REG_LAST:     last_q <= pwdata[pla_pkg::LAST_W-1:0];
				pla_pkg::REG_MULTILEN: mlen_q <= pwdata[pla_pkg::MLEN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pla_pkg::REG_MODE:     prdata = pla_pkg::DATA_W'(mode_q);
			pla_pkg::REG_TOP:      prdata = pla_pkg::DATA_W'(top_q);
			pla_pkg::REG_LAST:     prdata = pla_pkg::DATA_W'(last_q);
			pla_pkg::REG_MULTILEN: prdata = pla_pkg::DATA_W'(mlen_q);
		endcase
	end

	pla_ctrl #(.MAX_LEN(MAX_LEN), .MAX_MULTI(MAX_MULTI), .VALUE_BITS(VALUE_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.mode(mode_q), .top_value(top_q), .last_pos(last_q), .multiset_len(mlen_q),
		.cmd(cmd), .sts(sts),
		.arr_waddr(arr_waddr), .arr_wdata(arr_wdata), .arr_raddr(arr_raddr),
		.arr_rdata(arr_rdata), .ms_waddr(ms_waddr), .ms_wdata(ms_wdata),
		.ms_raddr(ms_raddr), .ms_rdata(ms_rdata), .out_pos(out_pos), .out_elem(out_elem)
	);

	pla_datapath #(.MAX_LEN(MAX_LEN), .MAX_MULTI(MAX_MULTI), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.arr_waddr(arr_waddr), .arr_wdata(arr_wdata), .arr_raddr(arr_raddr),
		.arr_rdata(arr_rdata), .ms_waddr(ms_waddr), .ms_wdata(ms_wdata),
		.ms_raddr(ms_raddr), .ms_rdata(ms_rdata), .out_pos(out_pos), .out_elem(out_elem),
		.out_ch(out_ch)
	);
endmodule
